@@ hdl/bpa_pkg.sv @@
// Buddy page allocator package: sizes, field codes, metadata word layout,
// request/result structs and the sequencer state type. No dependencies.
package bpa_pkg;

  localparam int PAGES    = 4096;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int LINK_W   = PAGE_W + 1;
  localparam int ORDERS   = 11;
  localparam int ORD_W    = 4;
  localparam int LIM_W    = 13;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGES);

  // page states
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_USED     = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  // request codes
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;

  // result codes
  localparam logic [2:0] S_OK        = 3'd0;
  localparam logic [2:0] S_OOM       = 3'd1;
  localparam logic [2:0] S_BAD_ORDER = 3'd2;
  localparam logic [2:0] S_DOUBLE    = 3'd3;
  localparam logic [2:0] S_RANGE     = 3'd4;

  // register index
  localparam logic [2:0] REG_PAGES_IN_USE = 3'd0;

  typedef struct packed {
    logic [LINK_W-1:0] prv;
    logic [LINK_W-1:0] nxt;
    logic [ORD_W-1:0]  ord;
    logic [1:0]        st;
  } meta_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic [ORD_W-1:0]  order;
    logic [1:0]        func;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] alloc_index;
    logic [2:0]        status;
  } res_t;

  typedef enum logic [3:0] {
    SQ_CLEAR, SQ_IDLE, SQ_F_CHK, SQ_M_TEST, SQ_M_CHK, SQ_A_SCAN, SQ_A_RD,
    SQ_U_ENTRY, SQ_U_PV, SQ_U_NX, SQ_U_NX2, SQ_U_SELF, SQ_A_SPLIT,
    SQ_P_START, SQ_P_FIX, SQ_DONE
  } seq_e;

  function automatic logic link_ok(logic [LINK_W-1:0] x);
    return x < LINK_W'(PAGES);
  endfunction

endpackage

@@ hdl/bpa_seq.sv @@
// Allocator sequencer: page metadata memory, free-list heads and the
// read-modify-write state machine for allocate, free and release. Uses bpa_pkg.
module bpa_seq import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] pages_in_use_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  // metadata memory
  meta_t mem [PAGES];
  meta_t rdata_q;
  logic              rd_en, wr_en;
  logic [PAGE_W-1:0] rd_addr, wr_addr;
  meta_t             wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  seq_e state_q, state_d;
  logic [LINK_W-1:0] head_q [ORDERS];
  logic [PAGE_W-1:0] clr_q, idx_q, h_q, p_q;
  logic [LINK_W-1:0] b_q, pv_q, nx_q, h2_q;
  logic [ORD_W-1:0]  ord_q, k_q, c_q;
  logic [1:0]        func_q;
  logic              merge_q;
  logic [2:0]        status_q;
  logic [PAGE_W-1:0] got_q;

  // held word of the block being unlinked: order and state kept for write-back
  meta_t self_q;

  // derived values
  logic [LIM_W-1:0]  lim;
  logic              req_bad, req_range;
  logic [PAGE_W-1:0] bm;
  logic              m_go;
  logic [LINK_W-1:0] pvn, nxn, bs;
  logic [ORD_W-1:0]  nc, uk;
  logic              chk_fail, buddy_fail;
  logic [1:0]        want_st;

  assign lim       = (pages_in_use_i > LIM_W'(PAGES)) ? LIM_W'(PAGES) : pages_in_use_i;
  assign req_bad   = ((req_i.func == FN_ALLOC) || (req_i.func == FN_FREE)) &&
                     (req_i.order > ORD_W'(ORDERS - 1));
  assign req_range = LIM_W'(req_i.page_index) >= lim;
  assign bm        = idx_q ^ (PAGE_W'(1) << k_q);
  assign m_go      = (k_q < ORD_W'(ORDERS - 1)) && (LIM_W'(bm) < lim);
  assign pvn       = link_ok(rdata_q.prv) ? rdata_q.prv : NIL;
  assign nxn       = link_ok(rdata_q.nxt) ? rdata_q.nxt : NIL;
  assign nc        = c_q - ORD_W'(1);
  assign bs        = LINK_W'(h_q) + (LINK_W'(1) << nc);
  assign uk        = merge_q ? k_q : c_q;
  assign want_st   = (func_q == FN_FREE) ? ST_USED : ST_RESERVED;
  assign chk_fail  = rdata_q.st != want_st;
  assign buddy_fail = (rdata_q.st != ST_FREE) || (rdata_q.ord != k_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_CLEAR:   if (clr_q == PAGE_W'(PAGES - 1)) state_d = SQ_IDLE;
      SQ_IDLE: begin
        if (req_valid_i) begin
          if (req_bad) state_d = SQ_DONE;
          else if (req_i.func == FN_ALLOC) state_d = SQ_A_SCAN;
          else if (req_i.func == FN_FREE || req_i.func == FN_RELEASE)
            state_d = req_range ? SQ_DONE : SQ_F_CHK;
          else state_d = SQ_DONE;
        end
      end
      SQ_F_CHK:   state_d = chk_fail ? SQ_DONE : SQ_M_TEST;
      SQ_M_TEST:  state_d = m_go ? SQ_M_CHK : SQ_P_START;
      SQ_M_CHK:   state_d = buddy_fail ? SQ_P_START : SQ_U_ENTRY;
      SQ_A_SCAN: begin
        if (c_q >= ORD_W'(ORDERS)) state_d = SQ_DONE;
        else if (link_ok(head_q[c_q])) state_d = SQ_A_RD;
      end
      SQ_A_RD:    state_d = SQ_U_ENTRY;
      SQ_U_ENTRY: state_d = link_ok(pvn) ? SQ_U_PV : SQ_U_NX;
      SQ_U_PV:    state_d = SQ_U_NX;
      SQ_U_NX:    state_d = link_ok(nx_q) ? SQ_U_NX2 : SQ_U_SELF;
      SQ_U_NX2:   state_d = SQ_U_SELF;
      SQ_U_SELF:  state_d = merge_q ? SQ_M_TEST : SQ_A_SPLIT;
      SQ_A_SPLIT: begin
        if (c_q > ord_q) begin
          if (link_ok(bs)) state_d = SQ_P_START;
        end else begin
          state_d = SQ_DONE;
        end
      end
      SQ_P_START: begin
        if (link_ok(head_q[uk])) state_d = SQ_P_FIX;
        else state_d = merge_q ? SQ_DONE : SQ_A_SPLIT;
      end
      SQ_P_FIX:   state_d = merge_q ? SQ_DONE : SQ_A_SPLIT;
      SQ_DONE:    if (res_ready_i) state_d = SQ_IDLE;
      default:    state_d = SQ_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata_q;
    unique case (state_q)
      SQ_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '{prv: NIL, nxt: NIL, ord: '0, st: ST_RESERVED};
      end
      SQ_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = req_i.page_index;
      end
      SQ_F_CHK: begin
        wr_en      = !chk_fail;
        wr_addr    = idx_q;
        wr_data.st = ST_FREE;
      end
      SQ_M_TEST: begin
        rd_en   = m_go;
        rd_addr = bm;
      end
      SQ_A_SCAN: begin
        rd_en   = c_q < ORD_W'(ORDERS);
        rd_addr = head_q[c_q][PAGE_W-1:0];
      end
      SQ_U_ENTRY: begin
        rd_en   = link_ok(pvn);
        rd_addr = pvn[PAGE_W-1:0];
      end
      SQ_U_PV: begin
        wr_en       = 1'b1;
        wr_addr     = pv_q[PAGE_W-1:0];
        wr_data.nxt = nx_q;
      end
      SQ_U_NX: begin
        rd_en   = link_ok(nx_q);
        rd_addr = nx_q[PAGE_W-1:0];
      end
      SQ_U_NX2: begin
        wr_en       = 1'b1;
        wr_addr     = nx_q[PAGE_W-1:0];
        wr_data.prv = pv_q;
      end
      SQ_U_SELF: begin
        wr_en   = 1'b1;
        wr_addr = p_q;
        wr_data = '{prv: NIL, nxt: NIL, ord: self_q.ord, st: self_q.st};
      end
      SQ_A_SPLIT: begin
        wr_en   = !(c_q > ord_q);
        wr_addr = h_q;
        wr_data = '{prv: NIL, nxt: NIL, ord: ord_q, st: ST_USED};
      end
      SQ_P_START: begin
        // push the block and fetch the old head for its back link
        rd_en   = link_ok(head_q[uk]);
        rd_addr = head_q[uk][PAGE_W-1:0];
        wr_en   = 1'b1;
        wr_addr = p_q;
        wr_data = '{prv: NIL, nxt: head_q[uk], ord: uk, st: ST_FREE};
      end
      SQ_P_FIX: begin
        wr_en       = 1'b1;
        wr_addr     = h2_q[PAGE_W-1:0];
        wr_data.prv = LINK_W'(p_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SQ_CLEAR;
      clr_q    <= '0;
      for (int i = 0; i < ORDERS; i++) head_q[i] <= NIL;
      func_q   <= FN_ALLOC;
      merge_q  <= 1'b0;
      status_q <= S_OK;
      got_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        SQ_CLEAR: clr_q <= clr_q + PAGE_W'(1);
        SQ_IDLE: begin
          if (req_valid_i) begin
            func_q   <= req_i.func;
            ord_q    <= req_i.order;
            idx_q    <= req_i.page_index;
            c_q      <= req_i.order;
            k_q      <= (req_i.func == FN_FREE) ? req_i.order : '0;
            merge_q  <= req_i.func != FN_ALLOC;
            got_q    <= '0;
            if (req_bad) status_q <= S_BAD_ORDER;
            else if ((req_i.func == FN_FREE || req_i.func == FN_RELEASE) && req_range)
              status_q <= S_RANGE;
            else status_q <= S_OK;
          end
        end
        SQ_F_CHK:  if (chk_fail) status_q <= S_DOUBLE;
        SQ_M_TEST: begin
          if (m_go) b_q <= LINK_W'(bm);
          else p_q <= idx_q;
        end
        SQ_M_CHK: p_q <= buddy_fail ? idx_q : b_q[PAGE_W-1:0];
        SQ_A_SCAN: begin
          if (c_q >= ORD_W'(ORDERS)) status_q <= S_OOM;
          else if (link_ok(head_q[c_q])) begin
            h_q <= head_q[c_q][PAGE_W-1:0];
            p_q <= head_q[c_q][PAGE_W-1:0];
          end else c_q <= c_q + ORD_W'(1);
        end
        SQ_U_ENTRY: begin
          pv_q   <= pvn;
          nx_q   <= nxn;
          self_q <= rdata_q;
          if (!link_ok(pvn)) head_q[uk] <= nxn;
        end
        SQ_U_SELF: begin
          if (merge_q) begin
            if (b_q[PAGE_W-1:0] < idx_q) idx_q <= b_q[PAGE_W-1:0];
            k_q <= k_q + ORD_W'(1);
          end
        end
        SQ_A_SPLIT: begin
          if (c_q > ord_q) begin
            c_q <= nc;
            p_q <= bs[PAGE_W-1:0];
          end else got_q <= h_q;
        end
        SQ_P_START: begin
          head_q[uk] <= LINK_W'(p_q);
          h2_q       <= head_q[uk];
        end
        default: ;
      endcase
    end
  end

  assign req_ready_o = state_q == SQ_IDLE;
  assign res_valid_o = state_q == SQ_DONE;
  assign res_o       = '{alloc_index: got_q, status: status_q};

endmodule

@@ hdl/buddy_page_allocator.sv @@
// Buddy page allocator, top level: stream ports, APB register, result register.
// Depends on bpa_pkg and bpa_seq.
//
// Requests (allocate, free, release) are served one at a time by a sequencer
// that walks free lists in a single-port-read, single-port-write metadata
// memory of 4096 words. After reset the block runs a clearing pass over that
// memory and takes no request until it ends. A bad order or range error goes
// straight to the result, and a failed state check ends after the page's word
// is read; an allocate scans the empty orders, reaches and unlinks the head
// block and then splits it down; a free or release runs its merge steps and
// then pushes the result. Each step is bound by the memory's one read per
// cycle.
// A finished result waits in an output register while the next item runs.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: func[1:0], order[5:2], page_index[17:6], zero pad
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,
  // tdata: status[2:0], alloc_index[14:3], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LIM_W-1:0] pip_q;
  logic             res_valid, res_ready, out_valid_q;
  res_t             res, out_q;
  req_t             req;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pip_q <= LIM_W'(PAGES);
    else if (psel && penable && pwrite && paddr == REG_PAGES_IN_USE)
      pip_q <= pwdata[LIM_W-1:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PAGES_IN_USE) ? 32'(pip_q) : '0;

  assign req = req_t'(s_axis_tdata_i[$bits(req_t)-1:0]);

  bpa_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pages_in_use_i (pip_q),
    .req_valid_i    (s_axis_tvalid_i),
    .req_ready_o    (s_axis_tready_o),
    .req_i          (req),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_ready) out_valid_q <= res_valid;
  end
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = 16'(out_q);

endmodule

@@ hdl/bpa_checker.sv @@
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends only on the top level's ports.
module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        pready
);

  // a stalled result beat stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat dropped or changed while stalled");

  // status code within range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:0] <= 3'd4)
    else $error("bad status code");

  // index only given with success
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != 3'd0 |-> m_axis_tdata_o[14:3] == 12'd0)
    else $error("index on failed request");

  // pad bit and register port
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[15] && pready)
    else $error("pad bit set or port not ready");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .pready          (pready)
);

@@ sim/tb.sv @@
// Self-checking bench for the buddy page allocator: drives request beats, predicts
// each status/alloc_index from its own copy of page metadata. Depends on bpa_pkg.
module tb;
  import bpa_pkg::*;

  localparam logic [1:0] FN_NONE = 2'd3;   // unused selector
  localparam int WDOG_LIMIT = 20000;        // covers the clearing pass
  localparam int SETTLE = 150;              // worst-case item latency plus margin

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;                // func[1:0], order[5:2], page_index[17:6]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;                     // status[2:0], alloc_index[14:3]
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow allocator state
  logic [1:0]        shadow_st [PAGES];
  logic [3:0]        shadow_ord [PAGES];
  int unsigned       shadow_nxt [PAGES];
  int unsigned       shadow_prv [PAGES];
  int unsigned       shadow_head [ORDERS];
  int unsigned       managed_pages = 4096;

  res_t        pending_results[$];
  int unsigned owned_idx[$];
  int unsigned owned_ord[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  bit          calm = 1'b0;

  function automatic int unsigned page_limit();
    return managed_pages < PAGES ? managed_pages : PAGES;
  endfunction

  function automatic void list_push(int unsigned p, int unsigned k);
    int unsigned h;
    h = shadow_head[k];
    shadow_ord[p] = k[3:0];
    shadow_st[p] = ST_FREE;
    shadow_nxt[p] = h;
    shadow_prv[p] = PAGES;
    if (h < PAGES) shadow_prv[h] = p;
    shadow_head[k] = p;
  endfunction

  function automatic void list_unlink(int unsigned p, int unsigned k);
    int unsigned pv, nx;
    pv = shadow_prv[p];
    nx = shadow_nxt[p];
    if (nx >= PAGES) nx = PAGES;
    if (pv < PAGES) shadow_nxt[pv] = nx;
    else shadow_head[k] = nx;
    if (nx < PAGES) shadow_prv[nx] = (pv < PAGES) ? pv : PAGES;
    shadow_nxt[p] = PAGES;
    shadow_prv[p] = PAGES;
  endfunction

  function automatic void coalesce(int unsigned idx, int unsigned k);
    int unsigned lim, b;
    lim = page_limit();
    shadow_st[idx] = ST_FREE;
    while (k < ORDERS - 1) begin
      b = idx ^ (1 << k);
      if (b >= lim) break;
      if (shadow_st[b] != ST_FREE || shadow_ord[b] != k) break;
      list_unlink(b, k);
      if (b < idx) idx = b;
      k++;
    end
    list_push(idx, k);
  endfunction

  // predict one request, updating the shadow state
  function automatic res_t predict_alloc(req_t rq);
    res_t r;
    int unsigned c, h, b;
    r.status = S_OK;
    r.alloc_index = '0;
    if (rq.func == FN_ALLOC) begin
      if (rq.order > ORDERS - 1) r.status = S_BAD_ORDER;
      else begin
        r.status = S_OOM;
        for (c = rq.order; c < ORDERS; c++) begin
          h = shadow_head[c];
          if (h < PAGES) begin
            list_unlink(h, c);
            while (c > rq.order) begin
              c--;
              b = h + (1 << c);
              if (b < PAGES) list_push(b, c);
            end
            shadow_st[h] = ST_USED;
            shadow_ord[h] = rq.order;
            r.alloc_index = h[11:0];
            r.status = S_OK;
            break;
          end
        end
      end
    end else if (rq.func == FN_FREE) begin
      if (rq.order > ORDERS - 1) r.status = S_BAD_ORDER;
      else if (rq.page_index >= page_limit()) r.status = S_RANGE;
      else if (shadow_st[rq.page_index] != ST_USED) r.status = S_DOUBLE;
      else coalesce(rq.page_index, rq.order);
    end else if (rq.func == FN_RELEASE) begin
      if (rq.page_index >= page_limit()) r.status = S_RANGE;
      else if (shadow_st[rq.page_index] != ST_RESERVED) r.status = S_DOUBLE;
      else coalesce(rq.page_index, 0);
    end
    return r;
  endfunction

  // send one request beat, predict it once accepted
  task automatic send_req(logic [1:0] fn, logic [3:0] ord, logic [11:0] idx);
    req_t rq;
    res_t r;
    rq.func = fn;
    rq.order = ord;
    rq.page_index = idx;
    if (!calm && $urandom_range(3) == 0) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = {6'b0, rq};
    do @(posedge clk_i); while (!s_tready);
    r = predict_alloc(rq);
    pending_results.push_back(r);
    n_items++;
    if (fn == FN_ALLOC && r.status == S_OK) begin
      owned_idx.push_back(r.alloc_index);
      owned_ord.push_back(ord);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic drain();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned value);
    drain();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = {REG_PAGES_IN_USE[0], 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    managed_pages = value & 32'h1FFF;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (m_tvalid && m_tready) begin
      got = m_tdata[14:0];
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d alloc_index=%0d",
                 $time, got.status, got.alloc_index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          errors++;
        end
        if (got.alloc_index !== exp_r.alloc_index) begin
          $display("%0t: alloc_index expected %0d actual %0d",
                   $time, exp_r.alloc_index, got.alloc_index);
          errors++;
        end
      end
    end
  end

  // result-side backpressure in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (calm) m_tready = 1'b1;
      else if ($urandom_range(4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        m_tready = 1'b1;
      end else m_tready = 1'b1;
    end
  end

  // watchdog on cycles without any beat or register access
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // error paths and basic split/merge at full size
  task automatic test_directed();
    int i;
    send_req(FN_FREE, 4'd0, 12'd0);        // free of reserved page
    send_req(FN_ALLOC, 4'd15, 12'd0);      // bad order
    send_req(FN_FREE, 4'd11, 12'd5);       // bad order on free
    send_req(FN_ALLOC, 4'd0, 12'hFFF);     // nothing free yet
    send_req(FN_RELEASE, 4'd15, 12'd4095); // order ignored on release
    send_req(FN_RELEASE, 4'd0, 12'd4095);  // release of non-reserved page
    send_req(FN_NONE, 4'd9, 12'hABC);      // unused selector
    for (i = 0; i < 8; i++) send_req(FN_RELEASE, 4'd0, i[11:0]);
    send_req(FN_ALLOC, 4'd1, 12'd0);
    send_req(FN_ALLOC, 4'd0, 12'd0);
    send_req(FN_ALLOC, 4'd10, 12'd0);      // out of memory at top order
    send_req(FN_FREE, 4'd2, 12'd0);        // wrong order on free
    send_req(FN_FREE, 4'd0, 12'd0);        // now a double free
    send_req(FN_ALLOC, 4'd3, 12'd0);
    send_req(FN_FREE, 4'd10, 12'd2048);    // reserved, double free
  endtask

  // single managed page: range errors and a block at the edge
  task automatic test_tiny_limit();
    write_limit(1);
    send_req(FN_RELEASE, 4'd0, 12'd1);
    send_req(FN_RELEASE, 4'd0, 12'd4095);
    send_req(FN_FREE, 4'd0, 12'd2);
    send_req(FN_ALLOC, 4'd0, 12'd0);
    send_req(FN_FREE, 4'd0, 12'd0);
  endtask

  // mostly well-formed traffic with random content, some noise
  task automatic rand_traffic(int n, int unsigned span);
    int i, k;
    int unsigned r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) send_req(FN_RELEASE, 4'($urandom), 12'($urandom_range(span - 1)));
      else if (r < 62)
        send_req(FN_ALLOC, ($urandom_range(7) == 0) ? 4'($urandom_range(10))
                                                    : 4'($urandom_range(3)), 12'($urandom));
      else if (r < 90 && owned_idx.size() != 0) begin
        k = $urandom_range(owned_idx.size() - 1);
        send_req(FN_FREE, ($urandom_range(9) == 0) ? 4'($urandom_range(10))
                                                   : 4'(owned_ord[k]), 12'(owned_idx[k]));
        owned_idx.delete(k);
        owned_ord.delete(k);
      end else send_req(2'($urandom), 4'($urandom), 12'($urandom));
    end
  endtask

  task automatic test_wide_limit();
    write_limit(8191);                     // above PAGES, capped
    rand_traffic(100, 4096);
  endtask

  task automatic test_small_pool();
    write_limit(48);
    rand_traffic(60, 64);
    drain();                               // hold off until all results are in
    rand_traffic(60, 64);
  endtask

  task automatic test_steady_stream();
    write_limit(4096);
    calm = 1'b1;
    rand_traffic(130, 256);
  endtask

  initial begin
    int i;
    for (i = 0; i < PAGES; i++) begin
      shadow_st[i] = ST_RESERVED;
      shadow_ord[i] = '0;
      shadow_nxt[i] = PAGES;
      shadow_prv[i] = PAGES;
    end
    for (i = 0; i < ORDERS; i++) shadow_head[i] = PAGES;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_tiny_limit();
    test_wide_limit();
    test_small_pool();
    test_steady_stream();
    drain();

    $display("Covered %0d requests and %0d results: error codes, splits, merges,", n_items,
             n_results);
    $display("page limits 1, 48, 4096 and 8191, with random stalls on both sides.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
